// File: hw/rtl/tdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// shared widths, verdict codes and sequencer states of the trial division
// prime test core
// ----------------------------------------------------------------------------
package tdp_pkg;

    // width of the tested integer, sign bit included
    localparam int NUMBER_WIDTH = 32;
    // port width of the number field
    localparam int NUMBER_PORT_W = 32;
    // trial divisor never exceeds sqrt(2^(NUMBER_WIDTH-1)) + 1
    localparam int DIVISOR_W = NUMBER_WIDTH / 2 + 1;
    // running square of the divisor, with headroom
    localparam int SQUARE_W = NUMBER_WIDTH + 2;
    // divider step counter
    localparam int STEP_W = $clog2(NUMBER_WIDTH);

    typedef enum logic [1:0] {
        VERDICT_LOW       = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_COMPOSITE = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EVAL,
        ST_RESULT
    } tdp_state_t;

endpackage : tdp_pkg
`default_nettype wire

// File: hw/rtl/tdp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdp stream interfaces
// valid/ready channels for the number under test and for the verdict
// ----------------------------------------------------------------------------
interface tdp_number_if
    import tdp_pkg::*;
    ();
    logic                            valid;
    logic                            ready;
    logic signed [NUMBER_PORT_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface : tdp_number_if

interface tdp_verdict_if
    import tdp_pkg::*;
    ();
    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface : tdp_verdict_if
`default_nettype wire

// File: hw/rtl/trial_division_prime_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial division prime test core
// classifies one signed integer as below two, prime or composite by trying
// divisors 2, 3, 4 ... while divisor squared does not exceed the number
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload          | transfer when
//  ---------+-----+------------------+----------------------------
//  item     | in  | number  (32, s)  | item.valid  & item.ready
//  result   | out | verdict (2, u)   | result.valid & result.ready
//
// sequencing: one restoring divider step per cycle, NUMBER_WIDTH steps per
// trial divisor, plus a bound check and an evaluation between divisors; a
// 31-bit prime takes up to 46339 divisors (2 to 46340)
// numbers below two go straight to the result, with no divisor tried
// reset clears the sequencer to idle; item is ready only in idle
// a held verdict stays on result until its transfer, then idle again
//
module trial_division_prime_test_core
    import tdp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    tdp_number_if.sink    item,
    tdp_verdict_if.source result
);

    tdp_state_t              state_reg,   state_next;
    logic [NUMBER_WIDTH-1:0] number_reg,  number_next;   // held number under test
    logic [NUMBER_WIDTH-1:0] shift_reg,   shift_next;    // dividend bits, msb first
    logic [DIVISOR_W-1:0]    divisor_reg, divisor_next;
    logic [SQUARE_W-1:0]     square_reg,  square_next;   // divisor squared
    logic [DIVISOR_W-1:0]    rem_reg,     rem_next;      // partial remainder
    logic [STEP_W-1:0]       step_reg,    step_next;
    verdict_t                verdict_reg, verdict_next;

    // subtract/compare unit of the restoring divider
    logic [DIVISOR_W:0]      rem_trial;
    logic [DIVISOR_W:0]      rem_diff;
    logic                    rem_fits;

    logic [NUMBER_WIDTH-1:0] in_number;

    assign in_number = item.number[NUMBER_WIDTH-1:0];

    assign rem_trial = {rem_reg, shift_reg[NUMBER_WIDTH-1]};
    assign rem_diff  = rem_trial - {1'b0, divisor_reg};
    assign rem_fits  = (rem_trial >= {1'b0, divisor_reg});

    assign item.ready     = (state_reg == ST_IDLE);
    assign result.valid   = (state_reg == ST_RESULT);
    assign result.verdict = verdict_reg;

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        number_next  = number_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        square_next  = square_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        verdict_next = verdict_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    number_next  = in_number;
                    divisor_next = DIVISOR_W'(2);
                    square_next  = SQUARE_W'(4);
                    // negative, zero or one
                    if (in_number[NUMBER_WIDTH-1] ||
                        (in_number < NUMBER_WIDTH'(2)))
                    begin
                        verdict_next = VERDICT_LOW;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                // bound passed without a clean divide: prime
                if (square_reg > {2'b00, number_reg})
                begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    shift_next = number_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                rem_next   = rem_fits ? rem_diff[DIVISOR_W-1:0]
                                      : rem_trial[DIVISOR_W-1:0];
                shift_next = {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUMBER_WIDTH - 1))
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (rem_reg == '0)
                begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    divisor_next = divisor_reg + DIVISOR_W'(1);
                    square_next  = square_reg
                                 + {{(SQUARE_W-DIVISOR_W-1){1'b0}}, divisor_reg, 1'b0}
                                 + SQUARE_W'(1);
                    state_next   = ST_CHECK;
                end
            end

            ST_RESULT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        number_reg  <= number_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        square_reg  <= square_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        verdict_reg <= verdict_next;
    end

endmodule : trial_division_prime_test_core
`default_nettype wire

// File: tb/sv/prime_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime verdict checker
// watches the number and verdict channels, works out the verdict of every
// accepted number by its own trial division and compares it, in order, with
// the verdicts the core hands out
// ----------------------------------------------------------------------------
module prime_verdict_checker
    import tdp_pkg::*;
(
    input  wire    clk,
    input  wire    rst_n,
    tdp_number_if  item,
    tdp_verdict_if result,
    output int     fail_count,
    output int     pending,
    output int     low_count,
    output int     prime_count,
    output int     composite_count
);

    localparam logic [63:0] NUM_MASK = {64{1'b1}} >> (64 - NUMBER_WIDTH);
    localparam logic [63:0] NUM_SIGN = 64'd1 << (NUMBER_WIDTH - 1);
    localparam logic [63:0] FIRST_DIVISOR = 64'd2;

    typedef struct {
        logic signed [NUMBER_PORT_W-1:0] number;
        verdict_t                        verdict;
    } verdict_due_t;

    verdict_due_t verdicts_due[$];

    // bits above NUMBER_WIDTH are dropped; the search stops at the first
    // divisor that divides, and d <= n / d keeps d * d <= n without overflow
    function automatic verdict_t classify_number(input logic [NUMBER_PORT_W-1:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        verdict_t    v;
        n = 64'(raw) & NUM_MASK;
        if ((n & NUM_SIGN) != 0 || n < FIRST_DIVISOR)
            return VERDICT_LOW;
        v = VERDICT_PRIME;
        for (d = FIRST_DIVISOR; d <= n / d; d++)
        begin
            if (n % d == 0)
            begin
                v = VERDICT_COMPOSITE;
                break;
            end
        end
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_due_t head;
        verdict_due_t fresh;
        if (rst_n)
        begin
            // the core holds one number at a time, so retire before adding
            if (result.valid && result.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: verdict %0d with no number waiting for one",
                             $time, result.verdict);
                    fail_count++;
                end
                else
                begin
                    head = verdicts_due.pop_front();
                    if (result.verdict !== head.verdict)
                    begin
                        $display("%0t: verdict mismatch for %0d, expected %0d got %0d",
                                 $time, head.number, head.verdict, result.verdict);
                        fail_count++;
                    end
                    case (head.verdict)
                        VERDICT_LOW:   low_count++;
                        VERDICT_PRIME: prime_count++;
                        default:       composite_count++;
                    endcase
                end
            end
            if (item.valid && item.ready)
            begin
                fresh.number  = item.number;
                fresh.verdict = classify_number(item.number);
                verdicts_due.push_back(fresh);
            end
            pending = verdicts_due.size();
        end
    end

endmodule : prime_verdict_checker

// File: tb/sv/trial_division_prime_test_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial division prime test core testbench
// drives directed and random numbers into the core with random idle bursts
// on both channels, one long hold-off of the verdict channel and a full
// drain after each part, and leaves the checking to the verdict checker
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_test;
    import tdp_pkg::*;

    // verdict channel hold-off, long enough to stall the number channel
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 80;
    // random items at the end that run with no idling at all
    localparam int QUIET_ITEMS  = 25;
    // numbers below two finish quickly; allow a margin
    localparam int TAIL_CYCLES  = 20;

    logic clk;
    logic rst_n;

    // set by the stimulus, read by both channel drivers
    bit idle_on;
    // raised by the stimulus, cleared by the verdict driver when done
    bit long_hold;

    int fail_count;
    int pending;
    int low_count;
    int prime_count;
    int composite_count;
    int sent_count;

    tdp_number_if  number_ch ();
    tdp_verdict_if verdict_ch ();

    trial_division_prime_test_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (number_ch),
        .result (verdict_ch)
    );

    prime_verdict_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (number_ch),
        .result          (verdict_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .low_count       (low_count),
        .prime_count     (prime_count),
        .composite_count (composite_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial
    begin
        #30_000_000;
        $display("timeout with %0d verdicts outstanding", pending);
        $display("trial_division_prime_test_core_test NOT OK");
        $finish;
    end

    // verdict channel: random bursts of back-pressure, plus one long hold
    initial
    begin
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                verdict_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                // drop ready; the wait below and the next loop pass keep it low
                verdict_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
            end
        end
    end

    // offer one number and wait for its transfer; starts and ends at a
    // falling edge, valid stays high so back-to-back numbers need no gap
    task automatic send_number(input logic signed [NUMBER_PORT_W-1:0] n);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            number_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        number_ch.valid  <= 1'b1;
        number_ch.number <= n;
        do
            @(posedge clk);
        while (!(number_ch.valid && number_ch.ready));
        @(negedge clk);
        sent_count++;
    endtask

    // random numbers, mostly cheap for the iterative core: negatives, zero,
    // one, small values, large values with a small factor, products of two
    // small values, and at times a medium value that may be a slow prime
    function automatic logic signed [NUMBER_PORT_W-1:0] pick_number();
        int unsigned f;
        int unsigned a;
        int unsigned b;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 10)
            return $urandom | 32'h8000_0000;
        else if (kind < 15)
            return $urandom_range(0, 1);
        else if (kind < 55)
            return $urandom_range(2, 5000);
        else if (kind < 80)
        begin
            f = $urandom_range(2, 7);
            return f * $urandom_range(1, 32'h7FFF_FFFF / f);
        end
        else if (kind < 95)
        begin
            a = $urandom_range(2, 251);
            // squares of small values now and then
            b = ($urandom_range(0, 3) == 0) ? a : $urandom_range(2, 251);
            return a * b;
        end
        else
            return $urandom_range(2, 1 << 20);
    endfunction

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    logic signed [NUMBER_PORT_W-1:0] directed[$] = '{
        32'sh8000_0000,   // most negative
        -1,
        0,
        1,
        2,                // no divisor passes the bound
        3,
        4,                // smallest square
        5,
        9,
        25,
        49,
        97,
        121,
        65536,
        994009,           // square of a three-digit prime
        1000003,          // prime with 999 divisors tried
        32'sh7FFF_FFFE,   // largest even
        32'sh7FFF_FFFD,
        32'sh5555_5555,
        32'sh2AAA_AAAA,
        32'shAAAA_AAAA    // negative with alternating bits
    };

    initial
    begin
        rst_n            = 1'b0;
        number_ch.valid  = 1'b0;
        number_ch.number = '0;
        idle_on          = 1'b1;
        long_hold        = 1'b0;
        sent_count       = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part; the long hold starts around the tiny numbers so
        // the core fills up with a held verdict and the input stalls
        foreach (directed[i])
        begin
            if (i == 4)
                long_hold = 1'b1;
            send_number(directed[i]);
        end

        // sender pause until every verdict is back
        number_ch.valid <= 1'b0;
        wait_drained();
        @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            send_number(pick_number());
        end
        number_ch.valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tested %0d numbers: %0d below two, %0d prime, %0d composite",
                 sent_count, low_count, prime_count, composite_count);
        $display("with idle bursts on both channels, a long verdict hold and a full drain");
        if (fail_count == 0 && pending == 0)
            $display("trial_division_prime_test_core_test OK");
        else
            $display("trial_division_prime_test_core_test NOT OK");
        $finish;
    end

endmodule : trial_division_prime_test_core_test
